// File: rtl/core/tmm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Tiled matrix multiply package
// Shared widths, action and register codes, and the command and status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
package tmm_pkg;

    localparam int SIZE_W   = 7;   // width of the size registers and loop counters
    localparam int IDX_W    = 6;   // width of the row and column fields
    localparam int ELEM_W   = 16;  // width of an A or B element
    localparam int PROD_W   = 32;  // width of one element product
    localparam int RES_W    = 38;  // width of a C element
    localparam int CFG_IX_W = 1;   // width of the register index

    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    localparam logic [CFG_IX_W-1:0] REG_MATRIX_SIZE = 1'd0;
    localparam logic [CFG_IX_W-1:0] REG_TILE_SIZE   = 1'd1;

    localparam logic RESULT_DONE = 1'b0;
    localparam logic RESULT_READ = 1'b1;

    typedef struct packed {
        logic              load_a;     // write A at the request's row and column
        logic              load_b;     // write B at the request's row and column
        logic              rd_issue;   // read C for a read request
        logic              rd_zero;    // that read lies outside the computed matrix
        logic              mac_issue;  // read A(i,k) and B(k,j) into the MAC pipeline
        logic              mac_first;  // first product of this inner tile
        logic              c_rd;       // read the partial sum of C(i,j)
        logic              c_wr;       // write C(i,j) back
        logic              wr_first;   // first inner tile: overwrite instead of add
        logic              done_push;  // place the compute done result
        logic [SIZE_W-1:0] i;
        logic [SIZE_W-1:0] j;
        logic [SIZE_W-1:0] k;
    } tmm_cmd_t;

    typedef struct packed {
        logic rd_free;    // a read request may be taken this cycle
        logic done_free;  // the done result may be placed this cycle
    } tmm_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/tiled_matrix_multiply.sv
`default_nettype none
// Loads of A or B go one a cycle, back to back, while s_tready is high, with no result.
// A read passes the C read register and then the result register, and reads go one a
// cycle while s_tready is high. A compute is paced by the one multiply-accumulate and
// the read-modify-write of C after each inner tile.
// Reset sets matrix_size to 64 and tile_size to 16 and clears control; the
// stores are undefined until written, and C outside the last computed edge reads as zero.
// ---------------------------------------------------------------------------
// Tiled matrix multiply
// Square matrix product of signed 16-bit elements over configurable tiles,
// with stream request and result channels and a plain configuration port.
// ---------------------------------------------------------------------------
module tiled_matrix_multiply import tmm_pkg::*;
#(
    parameter int MAX_EDGE = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]   cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,   // row[5:0], col[11:6], value[27:12], zero
    input  wire logic [1:0]          s_tuser,   // action[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,   // result_value[37:0], zero
    output logic [0:0]               m_tuser    // result_kind[0]
);

    tmm_cmd_t                 cmd;
    tmm_stat_t                stat;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     result_kind;
    logic signed [RES_W-1:0]  result_value;

    assign row   = s_tdata[5:0];
    assign col   = s_tdata[11:6];
    assign value = s_tdata[27:12];

    tmm_ctrl #(
        .MAX_EDGE (MAX_EDGE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser),
        .row       (row),
        .col       (col),
        .cmd       (cmd),
        .stat      (stat)
    );

    tmm_datapath #(
        .MAX_EDGE (MAX_EDGE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .row          (row),
        .col          (col),
        .value        (value),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .result_kind  (result_kind),
        .result_value (result_value)
    );

    assign m_tdata = {2'b00, result_value};
    assign m_tuser = result_kind;

endmodule
`default_nettype wire

// File: rtl/core/tmm_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Tiled matrix multiply controller
// Holds the configuration, decodes requests and walks the tile loops,
// issuing one multiply-accumulate per cycle within an inner tile and a C update per element after each inner tile.
// ---------------------------------------------------------------------------
module tmm_ctrl import tmm_pkg::*;
#(
    parameter int MAX_EDGE = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]   cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [1:0]          action,
    input  wire logic [IDX_W-1:0]    row,
    input  wire logic [IDX_W-1:0]    col,
    output tmm_cmd_t                 cmd,
    input  wire tmm_stat_t           stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_WAIT2 = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [8:0] EDGE_L = 9'(MAX_EDGE);

    logic [2:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] tile_reg, tile_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic [SIZE_W-1:0] t_reg, t_next;
    logic [SIZE_W-1:0] r0_reg, r0_next;
    logic [SIZE_W-1:0] c0_reg, c0_next;
    logic [SIZE_W-1:0] k0_reg, k0_next;
    logic [SIZE_W-1:0] i_reg, i_next;
    logic [SIZE_W-1:0] j_reg, j_next;
    logic [SIZE_W-1:0] k_reg, k_next;
    logic [SIZE_W-1:0] rend_reg, rend_next;
    logic [SIZE_W-1:0] cend_reg, cend_next;
    logic [SIZE_W-1:0] kend_reg, kend_next;

    logic [SIZE_W-1:0] n_cfg;
    logic [SIZE_W-1:0] t_cfg;
    logic [SIZE_W-1:0] e0_cfg;
    logic              in_store;
    logic [SIZE_W:0]   i_inc, j_inc, k_inc;
    logic [SIZE_W:0]   r0_sum, c0_sum, k0_sum;

    function automatic logic [SIZE_W-1:0] tile_end(input logic [SIZE_W-1:0] start,
                                                   input logic [SIZE_W-1:0] t,
                                                   input logic [SIZE_W-1:0] n);
        logic [SIZE_W:0] sum;
        sum = {1'b0, start} + {1'b0, t};
        return (sum >= {1'b0, n}) ? n : sum[SIZE_W-1:0];
    endfunction

    // The matrix edge saturates at the store edge; a zero tile acts as one.
    assign n_cfg    = ({2'b00, size_reg} > EDGE_L) ? SIZE_W'(MAX_EDGE) : size_reg;
    assign t_cfg    = (tile_reg == '0) ? SIZE_W'(1) : tile_reg;
    assign e0_cfg   = tile_end('0, t_cfg, n_cfg);
    assign in_store = ({3'b000, row} < EDGE_L) && ({3'b000, col} < EDGE_L);

    assign i_inc  = {1'b0, i_reg} + 1'b1;
    assign j_inc  = {1'b0, j_reg} + 1'b1;
    assign k_inc  = {1'b0, k_reg} + 1'b1;
    assign r0_sum = {1'b0, r0_reg} + {1'b0, t_reg};
    assign c0_sum = {1'b0, c0_reg} + {1'b0, t_reg};
    assign k0_sum = {1'b0, k0_reg} + {1'b0, t_reg};

    always_comb
    begin
        size_next  = size_reg;
        tile_next  = tile_reg;
        state_next = state_reg;
        n_next     = n_reg;
        t_next     = t_reg;
        r0_next    = r0_reg;
        c0_next    = c0_reg;
        k0_next    = k0_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        rend_next  = rend_reg;
        cend_next  = cend_reg;
        kend_next  = kend_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.i      = i_reg;
        cmd.j      = j_reg;
        cmd.k      = k_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATRIX_SIZE: size_next = cfg_data;
                REG_TILE_SIZE:   tile_next = cfg_data;
                default:         size_next = size_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = stat.rd_free;
                if (s_tvalid && stat.rd_free)
                begin
                    unique case (action)
                        ACT_LOAD_A: cmd.load_a = in_store;
                        ACT_LOAD_B: cmd.load_b = in_store;
                        ACT_COMPUTE:
                        begin
                            n_next     = n_cfg;
                            t_next     = t_cfg;
                            r0_next    = '0;
                            c0_next    = '0;
                            k0_next    = '0;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            rend_next  = e0_cfg;
                            cend_next  = e0_cfg;
                            kend_next  = e0_cfg;
                            state_next = (n_cfg == '0) ? S_DONE : S_MAC;
                        end
                        ACT_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                            cmd.rd_zero  = !(({1'b0, row} < n_reg) && ({1'b0, col} < n_reg));
                        end
                        default: cmd.load_a = 1'b0;
                    endcase
                end
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (k_reg == k0_reg);
                if (k_inc == {1'b0, kend_reg})
                    state_next = S_WAIT1;
                else
                    k_next = k_inc[SIZE_W-1:0];
            end
            S_WAIT1:
            begin
                cmd.c_rd   = 1'b1;
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.c_wr     = 1'b1;
                cmd.wr_first = (k0_reg == '0);
                state_next   = S_MAC;
                priority if (j_inc < {1'b0, cend_reg})
                begin
                    j_next = j_inc[SIZE_W-1:0];
                    k_next = k0_reg;
                end
                else if (i_inc < {1'b0, rend_reg})
                begin
                    i_next = i_inc[SIZE_W-1:0];
                    j_next = c0_reg;
                    k_next = k0_reg;
                end
                else if (k0_sum < {1'b0, n_reg})
                begin
                    k0_next   = k0_sum[SIZE_W-1:0];
                    kend_next = tile_end(k0_sum[SIZE_W-1:0], t_reg, n_reg);
                    i_next    = r0_reg;
                    j_next    = c0_reg;
                    k_next    = k0_sum[SIZE_W-1:0];
                end
                else if (c0_sum < {1'b0, n_reg})
                begin
                    c0_next   = c0_sum[SIZE_W-1:0];
                    cend_next = tile_end(c0_sum[SIZE_W-1:0], t_reg, n_reg);
                    k0_next   = '0;
                    kend_next = tile_end('0, t_reg, n_reg);
                    i_next    = r0_reg;
                    j_next    = c0_sum[SIZE_W-1:0];
                    k_next    = '0;
                end
                else if (r0_sum < {1'b0, n_reg})
                begin
                    r0_next   = r0_sum[SIZE_W-1:0];
                    rend_next = tile_end(r0_sum[SIZE_W-1:0], t_reg, n_reg);
                    c0_next   = '0;
                    cend_next = tile_end('0, t_reg, n_reg);
                    k0_next   = '0;
                    kend_next = tile_end('0, t_reg, n_reg);
                    i_next    = r0_sum[SIZE_W-1:0];
                    j_next    = '0;
                    k_next    = '0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.done_free)
                begin
                    cmd.done_push = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= SIZE_W'(64);
            tile_reg  <= SIZE_W'(16);
            n_reg     <= '0;
            t_reg     <= SIZE_W'(1);
            r0_reg    <= '0;
            c0_reg    <= '0;
            k0_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            rend_reg  <= '0;
            cend_reg  <= '0;
            kend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            tile_reg  <= tile_next;
            n_reg     <= n_next;
            t_reg     <= t_next;
            r0_reg    <= r0_next;
            c0_reg    <= c0_next;
            k0_reg    <= k0_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            rend_reg  <= rend_next;
            cend_reg  <= cend_next;
            kend_reg  <= kend_next;
        end
    end

    a_mac_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (k_reg >= k0_reg) && (k_reg < kend_reg))
        else $error("inner index left its tile");

    a_mac_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (i_reg < n_reg) && (j_reg < n_reg))
        else $error("element index beyond the matrix edge");

    a_write_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ($past(state_reg) == S_WAIT2))
        else $error("C update without the pipeline drain");

endmodule
`default_nettype wire

// File: rtl/core/tmm_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Tiled matrix multiply datapath
// A, B and C stores, the registered multiply-accumulate pipeline, the C
// read-modify-write and the result register.
// ---------------------------------------------------------------------------
module tmm_datapath import tmm_pkg::*;
#(
    parameter int MAX_EDGE = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tmm_cmd_t                 cmd,
    output tmm_stat_t                     stat,
    input  wire logic [IDX_W-1:0]         row,
    input  wire logic [IDX_W-1:0]         col,
    input  wire logic signed [ELEM_W-1:0] value,
    input  wire logic                     m_tready,
    output logic                          m_tvalid,
    output logic                          result_kind,
    output logic signed [RES_W-1:0]       result_value
);

    localparam int IW    = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = (IW > IDX_W) ? IW : IDX_W;
    localparam int YW    = (IW > SIZE_W) ? IW : SIZE_W;

    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [RES_W-1:0]  mem_c [DEPTH];

    logic [XW-1:0] row_x, col_x;
    logic [YW-1:0] i_x, j_x, k_x;
    logic [AW-1:0] addr_rc, addr_ik, addr_kj, addr_ij, c_raddr;

    logic signed [ELEM_W-1:0] a_q, b_q;
    logic signed [RES_W-1:0]  c_q;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RES_W-1:0]  acc_reg;
    logic signed [RES_W-1:0]  c_wdata;
    logic                     v1_reg, f1_reg, v2_reg, f2_reg;
    logic                     rv_reg, rzero_reg;
    logic                     ov_reg;
    logic                     okind_reg;
    logic signed [RES_W-1:0]  oval_reg;
    logic                     rd_move;

    assign row_x   = XW'(row);
    assign col_x   = XW'(col);
    assign i_x     = YW'(cmd.i);
    assign j_x     = YW'(cmd.j);
    assign k_x     = YW'(cmd.k);
    assign addr_rc = {row_x[IW-1:0], col_x[IW-1:0]};
    assign addr_ik = {i_x[IW-1:0], k_x[IW-1:0]};
    assign addr_kj = {k_x[IW-1:0], j_x[IW-1:0]};
    assign addr_ij = {i_x[IW-1:0], j_x[IW-1:0]};
    assign c_raddr = cmd.rd_issue ? addr_rc : addr_ij;

    // The first inner tile of an element overwrites whatever C held before.
    assign c_wdata = cmd.wr_first ? acc_reg : (c_q + acc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
            mem_a[addr_rc] <= value;
        if (cmd.mac_issue)
            a_q <= mem_a[addr_ik];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b)
            mem_b[addr_rc] <= value;
        if (cmd.mac_issue)
            b_q <= mem_b[addr_kj];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.c_wr)
            mem_c[addr_ij] <= c_wdata;
        if (cmd.rd_issue || cmd.c_rd)
            c_q <= mem_c[c_raddr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q * b_q;
        if (v2_reg)
        begin
            if (f2_reg)
                acc_reg <= {{(RES_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            else
                acc_reg <= acc_reg + {{(RES_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            f1_reg <= cmd.mac_first;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
        end
    end

    // A read waits in the C read register until the result register is free.
    assign rd_move        = rv_reg && (!ov_reg || m_tready);
    assign stat.rd_free   = !rv_reg || !ov_reg || m_tready;
    assign stat.done_free = !rv_reg && (!ov_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_issue)
                rv_reg <= 1'b1;
            else if (rd_move)
                rv_reg <= 1'b0;

            if (cmd.done_push || rd_move)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
            rzero_reg <= cmd.rd_zero;
        if (cmd.done_push)
        begin
            okind_reg <= RESULT_DONE;
            oval_reg  <= '0;
        end
        else if (rd_move)
        begin
            okind_reg <= RESULT_READ;
            oval_reg  <= rzero_reg ? '0 : c_q;
        end
    end

    assign m_tvalid     = ov_reg;
    assign result_kind  = okind_reg;
    assign result_value = oval_reg;

    a_write_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.c_wr |-> !v1_reg && !v2_reg && !cmd.mac_issue)
        else $error("C written while products are still in flight");

    a_done_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done_push |-> !rv_reg)
        else $error("done result would overtake a pending read");

    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (!rv_reg || rd_move))
        else $error("read issued over a pending read");

endmodule
`default_nettype wire
